>>> hdl/tccw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tccw_pkg;

	localparam int COLUMNS = 80;
	localparam int ROWS = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int COPY_COUNT = COLUMNS * (ROWS - 1);
	localparam int LAST_ROW_POS = COLUMNS * (ROWS - 1);

	localparam int ADDR_W = $clog2(CELL_COUNT);
	localparam int CNT_W = $clog2(CELL_COUNT + 1);
	localparam int ROW_W = $clog2(ROWS);
	localparam int COL_W = $clog2(COLUMNS);
	localparam int CELL_W = 16;

	localparam logic [1:0] CMD_PUT = 2'd0;
	localparam logic [1:0] CMD_READ = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;
	localparam logic [1:0] CMD_NONE = 2'd3;

	localparam logic [7:0] NEWLINE_CODE = 8'd10;

	localparam logic REG_FG = 1'b0;
	localparam logic REG_BG = 1'b1;

	localparam logic [3:0] FG_RESET = 4'd7;
	localparam logic [3:0] BG_RESET = 4'd0;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] char_code;
		logic [10:0] cell_index;
	} tccw_cmd_t;

	typedef struct packed {
		logic [7:0] cell_char;
		logic [7:0] cell_attr;
		logic [10:0] cursor_cell;
		logic scrolled;
	} tccw_rsp_t;

	typedef struct packed {
		logic adv;
		logic nl;
		logic home;
	} tccw_cur_ctl_t;

	typedef struct packed {
		logic we;
		logic [ADDR_W-1:0] waddr;
		logic [CELL_W-1:0] wdata;
		logic re;
		logic [ADDR_W-1:0] raddr;
	} tccw_ram_req_t;

endpackage
`default_nettype wire

>>> hdl/tccw_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module tccw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> hdl/tccw_cursor.sv
`timescale 1ns / 1ps
`default_nettype none
module tccw_cursor
	import tccw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire tccw_cur_ctl_t ctl,
	output logic [ADDR_W-1:0] pos,
	output logic wrap
);

	logic [ROW_W-1:0] row_q;
	logic [COL_W-1:0] col_q;
	logic [ADDR_W-1:0] pos_q;
	logic last_row;
	logic last_col;

	assign last_row = (row_q == ROW_W'(ROWS - 1));
	assign last_col = (col_q == COL_W'(COLUMNS - 1));
	// moving past the last row of the screen
	assign wrap = (ctl.adv && last_col && last_row) || (ctl.nl && last_row);
	assign pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
			pos_q <= '0;
		end else if (ctl.home) begin
			row_q <= '0;
			col_q <= '0;
			pos_q <= '0;
		end else if (wrap) begin
			row_q <= ROW_W'(ROWS - 1);
			col_q <= '0;
			pos_q <= ADDR_W'(LAST_ROW_POS);
		end else if (ctl.nl) begin
			row_q <= row_q + 1'b1;
			col_q <= '0;
			pos_q <= pos_q + ADDR_W'(COLUMNS) - ADDR_W'(col_q);
		end else if (ctl.adv) begin
			pos_q <= pos_q + 1'b1;
			if (last_col) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> hdl/tccw_sweep.sv
`timescale 1ns / 1ps
`default_nettype none
module tccw_sweep
	import tccw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic copy,
	input wire logic [CELL_W-1:0] rdata,
	output tccw_ram_req_t req,
	output logic busy,
	output logic done
);

	logic active_q;
	logic copy_q;
	logic [CNT_W-1:0] cnt_q;
	logic pend_s1;
	logic zero_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic issuing;
	logic [CNT_W-1:0] src;

	assign issuing = active_q && (cnt_q < CNT_W'(CELL_COUNT));
	assign src = cnt_q + CNT_W'(COLUMNS);
	assign busy = active_q;
	// last write drains in the same cycle
	assign done = active_q && (cnt_q == CNT_W'(CELL_COUNT));

	always_comb begin
		req.re = issuing && copy_q && (cnt_q < CNT_W'(COPY_COUNT));
		req.raddr = src[ADDR_W-1:0];
		req.we = pend_s1;
		req.waddr = addr_s1;
		req.wdata = zero_s1 ? '0 : rdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			// clearing pass over the whole store after reset
			active_q <= 1'b1;
			copy_q <= 1'b0;
			cnt_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= issuing;
			if (start) begin
				active_q <= 1'b1;
				copy_q <= copy;
				cnt_q <= '0;
			end else if (done) begin
				active_q <= 1'b0;
			end else if (issuing) begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (issuing) begin
			addr_s1 <= cnt_q[ADDR_W-1:0];
			zero_s1 <= !copy_q || (cnt_q >= CNT_W'(COPY_COUNT));
		end
	end

endmodule
`default_nettype wire

>>> hdl/text_console_char_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// Text console cell writer: a ROWS x COLUMNS store of 16-bit cells (attribute in the high
// byte, character in the low byte) held in one simple dual-port RAM, plus a cursor. Every
// request yields exactly one response. A put (ordinary character or newline) or an unused
// command goes straight to the response register; a read inside the store first waits for
// the registered RAM output. A put that runs off the end of the screen, and a clear, run a
// sweep over the RAM that touches one cell per cycle through its single write port. After
// reset the same sweep clears the store before the first request is taken; colour registers
// may be written at any time and take effect on the next put.
module text_console_char_writer
	import tccw_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	output logic cmd_ready,
	input wire tccw_cmd_t cmd_data,
	output logic rsp_valid,
	input wire logic rsp_ready,
	output tccw_rsp_t rsp_data,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic cfg_index,
	input wire logic [3:0] cfg_data
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDWAIT = 3'd1;
	localparam logic [2:0] ST_SWEEP = 3'd2;
	localparam logic [2:0] ST_INIT = 3'd3;
	localparam logic [2:0] ST_RESP = 3'd4;

	logic [2:0] state_q;
	logic [3:0] fg_q;
	logic [3:0] bg_q;
	logic [7:0] rd_char_q;
	logic [7:0] rd_attr_q;
	logic scrolled_q;
	logic rsp_valid_q;
	tccw_rsp_t rsp_q;

	logic accept;
	logic is_put;
	logic is_nl;
	logic rd_hit;
	logic rsp_load;
	tccw_cur_ctl_t cur_ctl;
	logic [ADDR_W-1:0] cur_pos;
	logic cur_wrap;
	logic sweep_start;
	logic sweep_copy;
	logic sweep_busy;
	logic sweep_done;
	tccw_ram_req_t sweep_req;
	tccw_ram_req_t ram_req;
	logic [CELL_W-1:0] ram_rdata;

	assign cmd_ready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign accept = cmd_valid && cmd_ready;
	assign is_put = (cmd_data.cmd == CMD_PUT);
	assign is_nl = (cmd_data.char_code == NEWLINE_CODE);
	assign rd_hit = (cmd_data.cell_index < 11'(CELL_COUNT));
	// response register is free or being emptied this cycle
	assign rsp_load = (state_q == ST_RESP) && (!rsp_valid_q || rsp_ready);

	always_comb begin
		cur_ctl.adv = accept && is_put && !is_nl;
		cur_ctl.nl = accept && is_put && is_nl;
		cur_ctl.home = accept && (cmd_data.cmd == CMD_CLEAR);
	end

	assign sweep_start = (accept && is_put && cur_wrap) || cur_ctl.home;
	assign sweep_copy = !cur_ctl.home;

	tccw_cursor u_cursor (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(cur_ctl),
		.pos(cur_pos),
		.wrap(cur_wrap)
	);

	tccw_sweep u_sweep (
		.clk(clk),
		.arst_n(arst_n),
		.start(sweep_start),
		.copy(sweep_copy),
		.rdata(ram_rdata),
		.req(sweep_req),
		.busy(sweep_busy),
		.done(sweep_done)
	);

	// request path owns the ram in idle, the sweep otherwise
	always_comb begin
		if (state_q == ST_IDLE) begin
			ram_req.we = cur_ctl.adv;
			ram_req.waddr = cur_pos;
			ram_req.wdata = {bg_q, fg_q, cmd_data.char_code};
			ram_req.re = accept && (cmd_data.cmd == CMD_READ) && rd_hit;
			ram_req.raddr = cmd_data.cell_index[ADDR_W-1:0];
		end else begin
			ram_req = sweep_req;
		end
	end

	tccw_ram #(
		.WIDTH(CELL_W),
		.DEPTH(CELL_COUNT)
	) u_ram (
		.clk(clk),
		.we(ram_req.we),
		.waddr(ram_req.waddr),
		.wdata(ram_req.wdata),
		.re(ram_req.re),
		.raddr(ram_req.raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fg_q <= FG_RESET;
			bg_q <= BG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FG: fg_q <= cfg_data;
				REG_BG: bg_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (sweep_start) begin
							state_q <= ST_SWEEP;
						end else if (ram_req.re) begin
							state_q <= ST_RDWAIT;
						end else begin
							state_q <= ST_RESP;
						end
					end
				end
				ST_RDWAIT: state_q <= ST_RESP;
				ST_SWEEP: begin
					if (sweep_done) begin
						state_q <= ST_RESP;
					end
				end
				ST_INIT: begin
					if (sweep_done) begin
						state_q <= ST_IDLE;
					end
				end
				ST_RESP: begin
					if (rsp_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_char_q <= '0;
			rd_attr_q <= '0;
			scrolled_q <= is_put && cur_wrap;
		end else if (state_q == ST_RDWAIT) begin
			rd_char_q <= ram_rdata[7:0];
			rd_attr_q <= ram_rdata[15:8];
		end
		if (rsp_load) begin
			rsp_q.cell_char <= rd_char_q;
			rsp_q.cell_attr <= rd_attr_q;
			rsp_q.cursor_cell <= 11'(cur_pos);
			rsp_q.scrolled <= scrolled_q;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data = rsp_q;

	a_no_request_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		sweep_busy |-> !cmd_ready)
		else $error("request taken while sweep is running");

	a_cursor_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_pos < ADDR_W'(CELL_COUNT))
		else $error("cursor beyond last cell");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_RESP))
		else $error("response raised outside response state");

	a_scroll_cursor: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.scrolled) |-> (rsp_q.cursor_cell == 11'(LAST_ROW_POS)))
		else $error("scroll left cursor off last row start");

	a_sweep_owns_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RESP) |-> !sweep_req.we)
		else $error("sweep write still pending at response");

endmodule
`default_nettype wire
